### rtl/rpn_pkg.sv
package rpn_pkg;

  localparam int DATA_W            = 32;
  localparam int RPN_STACK_DEPTH   = 16;
  localparam int RPN_FRAC_BITS     = 16;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_EMIT = 3'd5
  } rpn_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } rpn_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_ALU,
    S_RESULT
  } rpn_state_e;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIX,
    A_DONE
  } rpn_alu_state_e;

  typedef struct packed {
    logic     start;
    rpn_cmd_e op;
  } rpn_alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } rpn_alu_rsp_t;

  // clamp a 33-bit signed sum to 32 bits
  function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] v);
    logic [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // clamp a 64-bit signed value to 32 bits
  function automatic logic [DATA_W-1:0] sat64(input logic [2*DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v[2*DATA_W-1:DATA_W-1] == {(DATA_W+1){v[2*DATA_W-1]}}) begin
      r = v[DATA_W-1:0];
    end else begin
      r = v[2*DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### rtl/rpn_in_if.sv
interface rpn_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        cmd;
  logic signed [rpn_pkg::DATA_W-1:0] operand;

  modport source (output valid, output cmd, output operand, input ready);
  modport sink (input valid, input cmd, input operand, output ready);
endinterface

### rtl/rpn_out_if.sv
interface rpn_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rpn_pkg::DATA_W-1:0] value;
  logic [1:0]                        status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

### rtl/rpn_stack.sv
module rpn_stack #(
  parameter int STACK_DEPTH = rpn_pkg::RPN_STACK_DEPTH,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rpn_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr_a,
  input  logic [AW-1:0]             rd_addr_b,
  output logic [rpn_pkg::DATA_W-1:0] rd_data_a,
  output logic [rpn_pkg::DATA_W-1:0] rd_data_b
);

  logic [rpn_pkg::DATA_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### rtl/rpn_alu.sv
module rpn_alu #(
  parameter int FRAC_BITS = rpn_pkg::RPN_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rpn_pkg::rpn_alu_req_t      req,
  input  logic [rpn_pkg::DATA_W-1:0] a,
  input  logic [rpn_pkg::DATA_W-1:0] b,
  output rpn_pkg::rpn_alu_rsp_t      rsp
);

  localparam int DW        = rpn_pkg::DATA_W;
  localparam int DIV_STEPS = DW + FRAC_BITS;
  localparam int SW        = $clog2(DIV_STEPS);
  localparam logic [SW-1:0] STEP_LAST = SW'(DIV_STEPS - 1);

  rpn_pkg::rpn_alu_state_e state, state_next;

  logic signed [2*DW-1:0] prod;
  logic signed [2*DW-1:0] prod_sh;
  logic [DW-1:0]          res;
  logic [DW-1:0]          dvd;
  logic [DW-1:0]          dvs;
  logic [DW-1:0]          rem;
  logic [DW:0]            q;
  logic                   ovf;
  logic                   neg;
  logic [SW-1:0]          step;
  logic [DW:0]            rem_sh;
  logic                   ge;
  logic [DW:0]            diff;
  logic [DW:0]            sum;
  logic [DW:0]            dif_ab;

  assign rem_sh  = {rem, dvd[DW-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign diff    = rem_sh - {1'b0, dvs};
  assign prod_sh = prod >>> FRAC_BITS;
  assign sum     = {a[DW-1], a} + {b[DW-1], b};
  assign dif_ab  = {a[DW-1], a} - {b[DW-1], b};

  assign rsp.done   = (state == rpn_pkg::A_DONE);
  assign rsp.result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpn_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rpn_pkg::A_IDLE: begin
        if (req.start) begin
          case (req.op)
            rpn_pkg::CMD_MUL: state_next = rpn_pkg::A_MUL;
            rpn_pkg::CMD_DIV: state_next = rpn_pkg::A_DIV;
            default:          state_next = rpn_pkg::A_DONE;
          endcase
        end
      end
      rpn_pkg::A_MUL: state_next = rpn_pkg::A_DONE;
      rpn_pkg::A_DIV: begin
        if (step == STEP_LAST) begin
          state_next = rpn_pkg::A_FIX;
        end
      end
      rpn_pkg::A_FIX:  state_next = rpn_pkg::A_DONE;
      rpn_pkg::A_DONE: state_next = rpn_pkg::A_IDLE;
      default:         state_next = rpn_pkg::A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      rpn_pkg::A_IDLE: begin
        if (req.start) begin
          prod <= $signed(a) * $signed(b);
          dvd  <= a[DW-1] ? (~a + 1'b1) : a;
          dvs  <= b[DW-1] ? (~b + 1'b1) : b;
          neg  <= a[DW-1] ^ b[DW-1];
          rem  <= '0;
          q    <= '0;
          ovf  <= 1'b0;
          step <= '0;
          case (req.op)
            rpn_pkg::CMD_ADD: res <= rpn_pkg::sat33(sum);
            rpn_pkg::CMD_SUB: res <= rpn_pkg::sat33(dif_ab);
            default:          res <= res;
          endcase
        end
      end
      rpn_pkg::A_MUL: res <= rpn_pkg::sat64(prod_sh);
      rpn_pkg::A_DIV: begin
        // one restoring step per cycle, zeros shift in below the dividend
        dvd  <= {dvd[DW-2:0], 1'b0};
        rem  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        q    <= {q[DW-1:0], ge};
        ovf  <= ovf | q[DW];
        step <= step + 1'b1;
      end
      rpn_pkg::A_FIX: begin
        if (neg) begin
          if (ovf || q > {2'b01, {(DW-1){1'b0}}}) begin
            res <= {1'b1, {(DW-1){1'b0}}};
          end else begin
            res <= ~q[DW-1:0] + 1'b1;
          end
        end else begin
          if (ovf || q[DW] || q[DW-1]) begin
            res <= {1'b0, {(DW-1){1'b1}}};
          end else begin
            res <= q[DW-1:0];
          end
        end
      end
      default: res <= res;
    endcase
  end

endmodule

### rtl/rpn_stack_calculator_top.sv
// Reverse Polish evaluator on a signed fixed-point operand stack of STACK_DEPTH
// entries with FRAC_BITS fraction bits. Tokens transfer in one at a time; the
// block is not ready while a token is in work. Emit and error tokens also wait
// for the result slot. Arithmetic runs on a single shared unit, whose divide
// is a one-bit-per-cycle restoring divide over 32 + FRAC_BITS quotient bits
// (Q16.16 at the default FRAC_BITS). Push and arithmetic tokens transfer no
// result; emit and every error transfer exactly one, with value zero on error.
module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = rpn_pkg::RPN_STACK_DEPTH,
  parameter int FRAC_BITS   = rpn_pkg::RPN_FRAC_BITS
) (
  input logic      clk,
  input logic      rst,
  rpn_in_if.sink   tokens,
  rpn_out_if.source results
);

  localparam int DW = rpn_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] TWO  = CW'(2);

  rpn_pkg::rpn_state_e   state, state_next;
  rpn_pkg::rpn_cmd_e     cmd;
  rpn_pkg::rpn_alu_req_t alu_req;
  rpn_pkg::rpn_alu_rsp_t alu_rsp;
  rpn_pkg::rpn_status_e  pend_status, pend_status_next;

  logic [DW-1:0] operand;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [DW-1:0] pend_value, pend_value_next;
  logic          pend_load;
  logic          out_load;
  logic          out_valid;
  logic [DW-1:0] out_value;
  logic [1:0]    out_status;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [DW-1:0] rd_data_a;
  logic [DW-1:0] rd_data_b;

  assign cnt_m1 = count - 1'b1;
  assign cnt_m2 = count - TWO;

  assign results.valid  = out_valid;
  assign results.value  = out_value;
  assign results.status = out_status;

  rpn_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(cnt_m2[AW-1:0]),
    .rd_addr_b(cnt_m1[AW-1:0]),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  rpn_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk(clk),
    .rst(rst),
    .req(alu_req),
    .a  (rd_data_a),
    .b  (rd_data_b),
    .rsp(alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpn_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tokens.valid && tokens.ready) begin
      cmd     <= rpn_pkg::rpn_cmd_e'(tokens.cmd);
      operand <= tokens.operand;
    end
    if (pend_load) begin
      pend_value  <= pend_value_next;
      pend_status <= pend_status_next;
    end
    if (out_load) begin
      out_value  <= pend_value;
      out_status <= pend_status;
    end
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    tokens.ready     = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = count[AW-1:0];
    wr_data          = operand;
    alu_req.start    = 1'b0;
    alu_req.op       = cmd;
    pend_load        = 1'b0;
    pend_value_next  = '0;
    pend_status_next = rpn_pkg::ST_OK;
    out_load         = 1'b0;
    case (state)
      rpn_pkg::S_IDLE: begin
        tokens.ready = 1'b1;
        if (tokens.valid) begin
          state_next = rpn_pkg::S_DECODE;
        end
      end
      rpn_pkg::S_DECODE: begin
        case (cmd)
          rpn_pkg::CMD_PUSH: begin
            if (count == FULL) begin
              pend_load        = 1'b1;
              pend_status_next = rpn_pkg::ST_OVER;
              state_next       = rpn_pkg::S_RESULT;
            end else begin
              wr_en      = 1'b1;
              count_next = count + 1'b1;
              state_next = rpn_pkg::S_IDLE;
            end
          end
          rpn_pkg::CMD_EMIT: begin
            if (count == '0) begin
              pend_load        = 1'b1;
              pend_status_next = rpn_pkg::ST_UNDER;
              state_next       = rpn_pkg::S_RESULT;
            end else begin
              state_next = rpn_pkg::S_READ;
            end
          end
          rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
            if (count < TWO) begin
              pend_load        = 1'b1;
              pend_status_next = rpn_pkg::ST_UNDER;
              state_next       = rpn_pkg::S_RESULT;
            end else begin
              state_next = rpn_pkg::S_READ;
            end
          end
          default: state_next = rpn_pkg::S_IDLE;
        endcase
      end
      rpn_pkg::S_READ: begin
        if (cmd == rpn_pkg::CMD_EMIT) begin
          pend_load       = 1'b1;
          pend_value_next = rd_data_b;
          count_next      = cnt_m1;
          state_next      = rpn_pkg::S_RESULT;
        end else if (cmd == rpn_pkg::CMD_DIV && rd_data_b == '0) begin
          pend_load        = 1'b1;
          pend_status_next = rpn_pkg::ST_DIVZ;
          state_next       = rpn_pkg::S_RESULT;
        end else begin
          alu_req.start = 1'b1;
          state_next    = rpn_pkg::S_ALU;
        end
      end
      rpn_pkg::S_ALU: begin
        if (alu_rsp.done) begin
          // result replaces the lower operand
          wr_en      = 1'b1;
          wr_addr    = cnt_m2[AW-1:0];
          wr_data    = alu_rsp.result;
          count_next = cnt_m1;
          state_next = rpn_pkg::S_IDLE;
        end
      end
      rpn_pkg::S_RESULT: begin
        if (!out_valid || results.ready) begin
          out_load   = 1'b1;
          state_next = rpn_pkg::S_IDLE;
        end
      end
      default: state_next = rpn_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/rpn_checker.sv
module rpn_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       tokens_valid,
  input logic                       tokens_ready,
  input logic [2:0]                 tokens_cmd,
  input logic                       results_valid,
  input logic                       results_ready,
  input logic [rpn_pkg::DATA_W-1:0] results_value,
  input logic [1:0]                 results_status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=>
      results_valid && $stable(results_value) && $stable(results_status))
    else $error("stalled result changed");

  // one token in work at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    tokens_valid && tokens_ready |=> !tokens_ready)
    else $error("ready right after a token transfer");

  // error results carry zero
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    results_valid && results_status != rpn_pkg::ST_OK |-> results_value == '0)
    else $error("error result with nonzero value");

  // unused codes are dropped quickly
  a_unused_quick: assert property (@(posedge clk) disable iff (rst)
    tokens_valid && tokens_ready && (tokens_cmd > rpn_pkg::CMD_EMIT)
      |=> ##1 tokens_ready)
    else $error("unused token code held the block");

endmodule

bind rpn_stack_calculator_top rpn_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .tokens_valid  (tokens.valid),
  .tokens_ready  (tokens.ready),
  .tokens_cmd    (tokens.cmd),
  .results_valid (results.valid),
  .results_ready (results.ready),
  .results_value (results.value),
  .results_status(results.status)
);
